// File: hw/rtl/bearing_measurement_jacobian_unit_macros.svh
// ----------------------------------------------------------------------------
// bearing measurement jacobian unit assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef BEARING_MEASUREMENT_JACOBIAN_UNIT_MACROS_SVH
`define BEARING_MEASUREMENT_JACOBIAN_UNIT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define BMJ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BMJ_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/bmj_pkg.sv
// ----------------------------------------------------------------------------
// bmj_pkg
// types, widths and the arctangent table of the bearing jacobian unit
// ----------------------------------------------------------------------------
package bmj_pkg;

  localparam int NST   = 2;   // stations
  localparam int QBITS = 33;  // quotient bits, one per cell
  localparam int CW    = 36;  // cordic x/y width
  localparam int RW    = 66;  // partial remainder width
  localparam int R2W   = 65;  // squared range width
  localparam int ACW   = 32;  // angle accumulator, 2^-32 turn

  typedef enum logic [1:0] {
    REG_S0X = 2'd0,
    REG_S0Y = 2'd1,
    REG_S1X = 2'd2,
    REG_S1Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [ACW-1:0]       acc;
    logic [RW-1:0]        rx;    // remainder for |dy|
    logic [RW-1:0]        ry;    // remainder for |dx|
    logic [QBITS-1:0]     qx;
    logic [QBITS-1:0]     qy;
    logic [R2W-1:0]       r2;
    logic                 big;
    logic                 hit;
    logic                 negx;  // -dy is negative
    logic                 negy;  // dx is negative
  } bmj_lane_t;

  typedef bmj_lane_t [NST-1:0] bmj_word_t;

  function automatic logic [ACW-1:0] atan_turn(input logic [4:0] k);
    logic [ACW-1:0] r;
    case (k)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/bmj_prep.sv
// ----------------------------------------------------------------------------
// bmj_prep
// offsets, squares, range and cordic start for both stations (3 stages)
// ----------------------------------------------------------------------------
module bmj_prep (
  input  logic                        clk,
  input  logic [2:0]                  en,
  input  logic signed [31:0]          target_x,
  input  logic signed [31:0]          target_y,
  input  logic [bmj_pkg::NST-1:0][31:0] st_x,
  input  logic [bmj_pkg::NST-1:0][31:0] st_y,
  output bmj_pkg::bmj_word_t          dout
);
  import bmj_pkg::*;

  logic signed [32:0] dx [NST];
  logic signed [32:0] dy [NST];
  bmj_word_t          s2;
  logic [63:0]        ax2 [NST];
  logic [63:0]        ay2 [NST];
  logic [31:0]        ax [NST];
  logic [31:0]        ay [NST];
  bmj_word_t          s2_next;
  bmj_word_t          dout_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NST; i++) begin
        dx[i] <= {target_x[31], target_x} - {st_x[i][31], st_x[i]};
        dy[i] <= {target_y[31], target_y} - {st_y[i][31], st_y[i]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      ax[i] = dx[i][32] ? 32'(-dx[i]) : dx[i][31:0];
      ay[i] = dy[i][32] ? 32'(-dy[i]) : dy[i][31:0];
      s2_next[i] = '0;
      s2_next[i].rx   = RW'(ay[i]);
      s2_next[i].ry   = RW'(ax[i]);
      s2_next[i].negx = !dy[i][32] && (dy[i] != '0);
      s2_next[i].negy = dx[i][32];
      s2_next[i].hit  = (dx[i] == '0) && (dy[i] == '0);
      if (dx[i][32]) begin
        s2_next[i].cx  = -CW'(dx[i]);
        s2_next[i].cy  = -CW'(dy[i]);
        s2_next[i].acc = 32'h8000_0000;
      end else begin
        s2_next[i].cx  = CW'(dx[i]);
        s2_next[i].cy  = CW'(dy[i]);
        s2_next[i].acc = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2 <= s2_next;
      for (int i = 0; i < NST; i++) begin
        ax2[i] <= {32'b0, ax[i]} * {32'b0, ax[i]};
        ay2[i] <= {32'b0, ay[i]} * {32'b0, ay[i]};
      end
    end
  end

  always_comb begin
    dout_next = s2;
    for (int i = 0; i < NST; i++) begin
      dout_next[i].r2  = {1'b0, ax2[i]} + {1'b0, ay2[i]};
      dout_next[i].big = dout_next[i].r2[R2W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dout <= dout_next;
    end
  end

endmodule

// File: hw/rtl/bmj_cell.sv
// ----------------------------------------------------------------------------
// bmj_cell
// one quotient bit and, below STEPS, one cordic micro-rotation per station
// ----------------------------------------------------------------------------
module bmj_cell #(
  parameter int IDX   = 0,
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  bmj_pkg::bmj_word_t din,
  output bmj_pkg::bmj_word_t dout
);
  import bmj_pkg::*;

  localparam bit ROT = (IDX < STEPS) && (IDX < 32);
  localparam int SH  = (IDX < 32) ? IDX : 31;
  localparam logic [4:0] K = SH[4:0];

  bmj_word_t            nxt;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [RW-1:0]        tx;
  logic [RW-1:0]        ty;
  logic                 bx;
  logic                 by;

  always_comb begin
    nxt = din;
    xs  = '0;
    ys  = '0;
    tx  = '0;
    ty  = '0;
    bx  = 1'b0;
    by  = 1'b0;
    for (int i = 0; i < NST; i++) begin
      if (ROT) begin
        xs = din[i].cx >>> SH;
        ys = din[i].cy >>> SH;
        if (!din[i].cy[CW-1]) begin
          nxt[i].cx  = din[i].cx + ys;
          nxt[i].cy  = din[i].cy - xs;
          nxt[i].acc = din[i].acc + atan_turn(K);
        end else begin
          nxt[i].cx  = din[i].cx - ys;
          nxt[i].cy  = din[i].cy + xs;
          nxt[i].acc = din[i].acc - atan_turn(K);
        end
      end
      // restoring division, first cell compares the unshifted numerator
      tx = (IDX == 0) ? din[i].rx : {din[i].rx[RW-2:0], 1'b0};
      ty = (IDX == 0) ? din[i].ry : {din[i].ry[RW-2:0], 1'b0};
      bx = tx >= {1'b0, din[i].r2};
      by = ty >= {1'b0, din[i].r2};
      nxt[i].rx = bx ? tx - {1'b0, din[i].r2} : tx;
      nxt[i].ry = by ? ty - {1'b0, din[i].r2} : ty;
      nxt[i].qx = {din[i].qx[QBITS-2:0], bx};
      nxt[i].qy = {din[i].qy[QBITS-2:0], by};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// File: hw/rtl/bmj_final.sv
// ----------------------------------------------------------------------------
// bmj_final
// bearing rounding, jacobian sign and saturation, output register
// ----------------------------------------------------------------------------
module bmj_final (
  input  logic                          clk,
  input  logic                          en,
  input  bmj_pkg::bmj_word_t            din,
  output logic [bmj_pkg::NST-1:0][15:0] bearing,
  output logic [bmj_pkg::NST-1:0][31:0] jac_x,
  output logic [bmj_pkg::NST-1:0][31:0] jac_y,
  output logic [bmj_pkg::NST-1:0]       hit
);
  import bmj_pkg::*;

  function automatic logic [31:0] sat_q(input logic [QBITS-1:0] q, input logic neg,
                                        input logic zero);
    logic [QBITS-1:0] m;
    logic [31:0]      r;
    m = q;
    if (zero) begin
      r = '0;
    end else if (neg) begin
      if (q > QBITS'(33'h0_8000_0000)) m = QBITS'(33'h0_8000_0000);
      r = 32'(-m);
    end else begin
      if (q > QBITS'(33'h0_7FFF_FFFF)) m = QBITS'(33'h0_7FFF_FFFF);
      r = m[31:0];
    end
    return r;
  endfunction

  logic [ACW-1:0] rnd [NST];

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      rnd[i] = din[i].acc + 32'h0000_8000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        bearing[i] <= din[i].hit ? 16'd0 : rnd[i][31:16];
        jac_x[i]   <= sat_q(din[i].qx, din[i].negx, din[i].hit || din[i].big);
        jac_y[i]   <= sat_q(din[i].qy, din[i].negy, din[i].hit || din[i].big);
        hit[i]     <= din[i].hit;
      end
    end
  end

endmodule

// File: hw/rtl/bearing_measurement_jacobian_unit.sv
// ----------------------------------------------------------------------------
// bearing measurement jacobian unit
// bearings and jacobian rows of a target seen from two fixed stations
// ----------------------------------------------------------------------------
// usage:
//   s_tdata carries one target position item, m_tdata/m_tuser one result item
//   stations are written on the cfg port while the unit is idle
//   a result passes three prep stages (offsets, squares, range), a row of
//   33 cells and one output register; each cell computes one quotient bit
//   of the four jacobian divisions and, below CORDIC_STEPS, one cordic
//   micro-rotation; a new item can enter every cycle while s_tready is high
//   ready ripples back along the chain: a stage loads when it is empty or
//   the stage after it moves, so a stalled receiver only holds the full
//   stages and empty slots further up still take new items
//   when every stage is full and m_tready is low, s_tready drops
//   reset clears the station positions to zero and empties the pipeline
// ----------------------------------------------------------------------------
module bearing_measurement_jacobian_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // config port
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // target_x, target_y
  // result items
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // bearing0, bearing1, jac0_wrt_x, jac0_wrt_y,
                                  // jac1_wrt_x, jac1_wrt_y
  output logic [1:0]   m_tuser    // on_station
);
  import bmj_pkg::*;

  localparam int NPREP  = 3;
  localparam int NSTAGE = NPREP + QBITS + 1;

  // station registers
  logic [NST-1:0][31:0] st_x;
  logic [NST-1:0][31:0] st_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_x <= '0;
      st_y <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_S0X: st_x[0] <= cfg_data;
        REG_S0Y: st_y[0] <= cfg_data;
        REG_S1X: st_x[1] <= cfg_data;
        REG_S1Y: st_y[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and per-stage load enables
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = !vld[NSTAGE-1] || m_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[NSTAGE-1];

  // prep stages
  bmj_word_t chain [QBITS+1];

  bmj_prep u_prep (
    .clk      (clk),
    .en       (adv[NPREP-1:0]),
    .target_x (s_tdata[31:0]),
    .target_y (s_tdata[63:32]),
    .st_x     (st_x),
    .st_y     (st_y),
    .dout     (chain[0])
  );

  // row of cells, one quotient bit each, one rotation each below CORDIC_STEPS
  for (genvar g = 0; g < QBITS; g++) begin : g_cell
    bmj_cell #(
      .IDX   (g),
      .STEPS (CORDIC_STEPS)
    ) u_cell (
      .clk  (clk),
      .en   (adv[NPREP+g]),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  // output register
  logic [NST-1:0][15:0] bearing;
  logic [NST-1:0][31:0] jac_x;
  logic [NST-1:0][31:0] jac_y;
  logic [NST-1:0]       hit;

  bmj_final u_final (
    .clk     (clk),
    .en      (adv[NSTAGE-1]),
    .din     (chain[QBITS]),
    .bearing (bearing),
    .jac_x   (jac_x),
    .jac_y   (jac_y),
    .hit     (hit)
  );

  assign m_tdata = {jac_y[1], jac_x[1], jac_y[0], jac_x[0], bearing[1], bearing[0]};
  assign m_tuser = hit;

endmodule

// File: hw/rtl/bmj_checker.sv
// ----------------------------------------------------------------------------
// bmj_checker
// port-level checks on the result channel of the bearing jacobian unit
// ----------------------------------------------------------------------------
`include "bearing_measurement_jacobian_unit_macros.svh"

module bmj_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [159:0] m_tdata,
  input logic [1:0]   m_tuser
);

  `BMJ_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `BMJ_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `BMJ_ASSERT_SAME(a_on_st0, m_tvalid && m_tuser[0], m_tdata[15:0] == 16'd0 && m_tdata[95:32] == 64'd0, "station 0 hit with nonzero row")
  `BMJ_ASSERT_SAME(a_on_st1, m_tvalid && m_tuser[1], m_tdata[31:16] == 16'd0 && m_tdata[159:96] == 64'd0, "station 1 hit with nonzero row")

endmodule

bind bearing_measurement_jacobian_unit bmj_checker u_bmj_checker (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// bearing measurement jacobian unit testbench
// drives target positions through the stream port against six station
// settings, predicts bearings, jacobian rows and on-station flags, and checks
// every result item in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import bmj_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = 40;
  localparam int WATCHDOG = 5000;

  typedef struct packed {
    logic [1:0]         on_station;
    logic signed [31:0] jac1_wrt_y;
    logic signed [31:0] jac1_wrt_x;
    logic signed [31:0] jac0_wrt_y;
    logic signed [31:0] jac0_wrt_x;
    logic [15:0]        bearing1;
    logic [15:0]        bearing0;
  } meas_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;      // target_x, target_y
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;           // bearing0, bearing1, jac0_wrt_x, jac0_wrt_y,
                                   // jac1_wrt_x, jac1_wrt_y
  logic [1:0]   m_tuser;           // on_station

  bearing_measurement_jacobian_unit #(.CORDIC_STEPS(STEPS)) uut (.*);

  always #6 clk = ~clk;

  // station positions as seen by the predictor
  logic signed [31:0] stn_x [2];
  logic signed [31:0] stn_y [2];

  logic [63:0] pending_targets [$];
  meas_t       expected_meas [$];
  int          mismatches = 0;
  bit          quiet_run = 1'b0;   // no idling on either side
  int          idle_cycles = 0;

  // cordic bearing, vectoring mode, 2^-32 turn accumulator
  function automatic logic [15:0] bearing_of(logic signed [32:0] dx, logic signed [32:0] dy);
    logic signed [40:0] x, y, xs, ys;
    logic [31:0] acc;
    acc = 32'h0;
    x = dx;
    y = dy;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    for (int k = 0; k < STEPS && k < 32; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + atan_turn(k[4:0]);
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - atan_turn(k[4:0]);
      end
    end
    acc = acc + 32'h8000;
    return acc[31:16];
  endfunction

  // floor(|num| * 2^32 / r2) with sign and saturation
  function automatic logic [31:0] jac_term(logic signed [33:0] num, logic [64:0] r2);
    logic [33:0] mag;
    logic [97:0] q;
    mag = (num < 0) ? -num : num;
    q = (r2[64] || r2 == 0) ? '0 : ({64'b0, mag} << 32) / {33'b0, r2};
    if (num < 0) begin
      if (q > 98'h8000_0000) q = 98'h8000_0000;
      return -q[31:0];
    end
    if (q > 98'h7FFF_FFFF) q = 98'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic meas_t predict_meas(logic [63:0] tgt);
    meas_t m;
    logic signed [32:0] dx, dy;
    logic [32:0] ax, ay;
    logic [64:0] r2;
    logic [15:0] brg [2];
    logic [31:0] jx [2], jy [2];
    for (int i = 0; i < 2; i++) begin
      dx = $signed(tgt[31:0]) - stn_x[i];
      dy = $signed(tgt[63:32]) - stn_y[i];
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      r2 = {32'b0, ax} * {32'b0, ax} + {32'b0, ay} * {32'b0, ay};
      if (dx == 0 && dy == 0) begin
        brg[i] = '0;
        jx[i] = '0;
        jy[i] = '0;
        m.on_station[i] = 1'b1;
      end else begin
        brg[i] = bearing_of(dx, dy);
        jx[i] = jac_term(-{dy[32], dy}, r2);
        jy[i] = jac_term({dx[32], dx}, r2);
        m.on_station[i] = 1'b0;
      end
    end
    m.bearing0 = brg[0];
    m.bearing1 = brg[1];
    m.jac0_wrt_x = jx[0];
    m.jac0_wrt_y = jy[0];
    m.jac1_wrt_x = jx[1];
    m.jac1_wrt_y = jy[1];
    return m;
  endfunction

  // driver: one item per accepted handshake
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_targets.size() > 0 && (quiet_run || $urandom_range(99) >= 8)) begin
        s_tdata <= pending_targets.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk) begin
    meas_t got, exp_m;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_meas.push_back(predict_meas(s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (expected_meas.size() == 0) begin
          $error("result item with no expectation");
          mismatches++;
        end else begin
          exp_m = expected_meas.pop_front();
          if (got.bearing0 !== exp_m.bearing0) begin
            $error("bearing0 exp %h got %h", exp_m.bearing0, got.bearing0);
            mismatches++;
          end
          if (got.bearing1 !== exp_m.bearing1) begin
            $error("bearing1 exp %h got %h", exp_m.bearing1, got.bearing1);
            mismatches++;
          end
          if (got.jac0_wrt_x !== exp_m.jac0_wrt_x) begin
            $error("jac0_wrt_x exp %h got %h", exp_m.jac0_wrt_x, got.jac0_wrt_x);
            mismatches++;
          end
          if (got.jac0_wrt_y !== exp_m.jac0_wrt_y) begin
            $error("jac0_wrt_y exp %h got %h", exp_m.jac0_wrt_y, got.jac0_wrt_y);
            mismatches++;
          end
          if (got.jac1_wrt_x !== exp_m.jac1_wrt_x) begin
            $error("jac1_wrt_x exp %h got %h", exp_m.jac1_wrt_x, got.jac1_wrt_x);
            mismatches++;
          end
          if (got.jac1_wrt_y !== exp_m.jac1_wrt_y) begin
            $error("jac1_wrt_y exp %h got %h", exp_m.jac1_wrt_y, got.jac1_wrt_y);
            mismatches++;
          end
          if (got.on_station !== exp_m.on_station) begin
            $error("on_station exp %h got %h", exp_m.on_station, got.on_station);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= quiet_run || ($urandom_range(99) >= 8);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_station(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_S0X: stn_x[0] = val;
      REG_S0Y: stn_y[0] = val;
      REG_S1X: stn_x[1] = val;
      default: stn_y[1] = val;
    endcase
  endtask

  // wait until every queued and expected item is through
  task automatic drain;
    wait (pending_targets.size() == 0 && !s_tvalid && expected_meas.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic push_target(logic [31:0] tx, logic [31:0] ty);
    pending_targets.push_back({ty, tx});
  endtask

  // random coordinate: mostly near the stations, sometimes anywhere
  function automatic logic [31:0] rand_coord(logic [31:0] base);
    case ($urandom_range(5))
      0: return $urandom;
      1: return base;
      2: return base + $urandom_range(8) - 4;
      3: return base + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
      default: return base + ($urandom & 32'h0FFF_FFFF) - 32'h0800_0000;
    endcase
  endfunction

  task automatic random_phase(int n);
    int s;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(1);
      push_target(rand_coord(stn_x[s]), rand_coord(stn_y[s]));
    end
  endtask

  initial begin
    stn_x[0] = 0; stn_y[0] = 0; stn_x[1] = 0; stn_y[1] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: both stations at the origin after reset
    push_target(32'h0, 32'h0);                   // target on both stations
    push_target(32'h0001_0000, 32'h0);
    push_target(32'h0, 32'h0001_0000);
    push_target(32'hFFFF_0000, 32'h0);           // dx negative, half turn start
    push_target(32'h0, 32'hFFFF_0000);
    push_target(32'h0001_0000, 32'hFFFF_FFFF);   // bearing rounds up to a full turn
    push_target(32'h8000_0000, 32'h8000_0000);   // r2 of 2^63, still within 64 bits
    push_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_target(32'h7FFF_FFFF, 32'h8000_0000);
    push_target(32'h0000_0001, 32'h0);           // jacobian saturates
    push_target(32'h0, 32'hFFFF_FFFF);
    push_target(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // extreme stations
    write_station(REG_S0X, 32'h7FFF_FFFF);
    write_station(REG_S0Y, 32'h8000_0000);
    write_station(REG_S1X, 32'h8000_0000);
    write_station(REG_S1Y, 32'h7FFF_FFFF);
    push_target(32'h8000_0000, 32'h7FFF_FFFF);   // 33-bit offsets, station 0
    push_target(32'h7FFF_FFFF, 32'h8000_0000);   // on station 0
    push_target(32'h8000_0000, 32'h7FFF_FFFF);   // on station 1
    push_target(32'h0, 32'h0);
    push_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    quiet_run = 1'b1;                            // long stretch with no idling
    random_phase(300);
    drain();
    quiet_run = 1'b0;

    // both stations on the same spot
    write_station(REG_S0X, 32'h0012_3456);
    write_station(REG_S0Y, 32'hFFF0_0000);
    write_station(REG_S1X, 32'h0012_3456);
    write_station(REG_S1Y, 32'hFFF0_0000);
    push_target(32'h0012_3456, 32'hFFF0_0000);
    random_phase(500);
    drain();

    // typical separated stations over the remaining phases
    for (int p = 0; p < 3; p++) begin
      write_station(REG_S0X, $urandom);
      write_station(REG_S0Y, $urandom);
      write_station(REG_S1X, $urandom & 32'h00FF_FFFF);
      write_station(REG_S1Y, -($urandom & 32'h00FF_FFFF));
      random_phase(380);
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
